// ----- rtl/core/dual_stack_shared_memory_top_defines.svh -----
// ----------------------------------------------------------------------------
// Dual stack shared memory assertion macros
// Shared property forms for the assertion checkers of the dual stack block.
// ----------------------------------------------------------------------------
`ifndef DUAL_STACK_SHARED_MEMORY_TOP_DEFINES_SVH
`define DUAL_STACK_SHARED_MEMORY_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define DSSM_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dssm assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define DSSM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dssm assertion failed");

`endif

// ----- rtl/core/dssm_pkg.sv -----
// ----------------------------------------------------------------------------
// Dual stack shared memory package
// Operation and status codes, capacity settings and stream widths of the dual stack block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dssm_pkg;

  localparam int CAP_BITS    = 5;
  localparam int CAP_RESET   = 16;
  localparam int VALUE_BITS  = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

endpackage

`default_nettype wire

// ----- rtl/core/dual_stack_shared_memory_top.sv -----
// ----------------------------------------------------------------------------
// Dual stack shared memory
// Two LIFO stacks, one growing up from word 0 and one growing down from the
// top of the configured capacity, kept in one synchronous word store.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one command per transfer: tdata holds the
// operation and the push value, tuser selects the stack. The master stream
// returns one result per command: peeked word, status and both empty flags.
// The capacity register is written through cfg_we_i and cfg_wdata_i; the user
// must do so only while the block is idle, which the block does not enforce. A
// write also empties both stacks. Stack pointers are updated when a command is
// accepted and the store is written or read in that same cycle, so the block
// takes one command per cycle while the output is not stalled. Each result
// passes through the read stage, where the store read is registered at the
// accepting edge, and then through the output register.
// When the receiver stalls, the result holds in the output register and one
// more command waits in the read stage; tready then drops until the output
// drains. Reset empties both stacks, sets the capacity to 16 and clears
// the pipeline; store contents are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dual_stack_shared_memory_top
  import dssm_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CAP_BITS-1:0]    cfg_wdata_i,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // [1:0] operation, [33:2] push_value, [39:34] zero.
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] stack_select.
  input  wire logic                   s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [31:0] top_value, [33:32] status, [34] lower_empty, [35] upper_empty,
  // [39:36] zero.
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int MW    = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;

  logic [CAP_BITS-1:0]   cap_q;
  logic [CNT_W-1:0]      lower_cnt_q, lower_cnt_d;
  logic [CNT_W-1:0]      upper_cnt_q, upper_cnt_d;
  logic [CNT_W-1:0]      eff_cap;
  logic [CNT_W:0]        used;
  logic [CNT_W-1:0]      up_push_idx, up_peek_idx, lo_peek_idx;

  logic                  in_fire;
  op_e                   op;
  logic                  sel_upper;
  logic [VALUE_BITS-1:0] push_value;

  logic                  we, re;
  logic [AW-1:0]         waddr, raddr;
  logic [WORD_BITS-1:0]  rdata;
  status_e               status;
  logic                  peek_hit, fill_ones;

  logic                  s1_valid_q, s1_adv;
  logic                  s1_peek_q, s1_ones_q, s1_le_q, s1_ue_q;
  status_e               s1_status_q;
  logic                  out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic [VALUE_BITS-1:0] s1_top;

  assign in_fire    = s_axis_tvalid && s_axis_tready;
  assign op         = op_e'(s_axis_tdata[1:0]);
  assign sel_upper  = s_axis_tuser;
  assign push_value = s_axis_tdata[VALUE_BITS+1:2];

  assign eff_cap     = (MW'(cap_q) > MW'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cap_q);
  assign used        = {1'b0, lower_cnt_q} + {1'b0, upper_cnt_q};
  assign up_push_idx = eff_cap - CNT_W'(1) - upper_cnt_q;
  assign up_peek_idx = eff_cap - upper_cnt_q;
  assign lo_peek_idx = lower_cnt_q - CNT_W'(1);

  always_comb begin
    lower_cnt_d = lower_cnt_q;
    upper_cnt_d = upper_cnt_q;
    we          = 1'b0;
    waddr       = lower_cnt_q[AW-1:0];
    re          = 1'b0;
    raddr       = lo_peek_idx[AW-1:0];
    status      = ST_OK;
    peek_hit    = 1'b0;
    fill_ones   = 1'b0;
    if (in_fire) begin
      case (op)
        OP_PUSH: begin
          if (used < {1'b0, eff_cap}) begin
            we = 1'b1;
            if (sel_upper) begin
              waddr       = up_push_idx[AW-1:0];
              upper_cnt_d = upper_cnt_q + CNT_W'(1);
            end else begin
              lower_cnt_d = lower_cnt_q + CNT_W'(1);
            end
          end else begin
            status = ST_OVERFLOW;
          end
        end
        OP_POP: begin
          if (sel_upper) begin
            if (upper_cnt_q != '0) upper_cnt_d = upper_cnt_q - CNT_W'(1);
            else status = ST_UNDERFLOW;
          end else begin
            if (lower_cnt_q != '0) lower_cnt_d = lower_cnt_q - CNT_W'(1);
            else status = ST_UNDERFLOW;
          end
        end
        OP_PEEK: begin
          if ((sel_upper ? upper_cnt_q : lower_cnt_q) == '0) begin
            status    = ST_UNDERFLOW;
            fill_ones = 1'b1;
          end else begin
            re       = 1'b1;
            peek_hit = 1'b1;
            if (sel_upper) raddr = up_peek_idx[AW-1:0];
          end
        end
        default: begin
          status = ST_OK;
        end
      endcase
    end
    if (cfg_we_i) begin
      lower_cnt_d = '0;
      upper_cnt_d = '0;
    end
  end

  dssm_ram #(
    .DEPTH (DEPTH),
    .WIDTH (WORD_BITS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (WORD_BITS'(push_value)),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;

  always_comb begin
    if (s1_peek_q) begin
      s1_top = VALUE_BITS'(signed'(rdata));
    end else if (s1_ones_q) begin
      s1_top = '1;
    end else begin
      s1_top = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_BITS'(CAP_RESET);
      lower_cnt_q <= '0;
      upper_cnt_q <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      lower_cnt_q <= lower_cnt_d;
      upper_cnt_q <= upper_cnt_d;
      if (in_fire) s1_valid_q <= 1'b1;
      else if (s1_adv) s1_valid_q <= 1'b0;
      if (s1_adv) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_peek_q   <= peek_hit;
      s1_ones_q   <= fill_ones;
      s1_status_q <= status;
      s1_le_q     <= (lower_cnt_d == '0);
      s1_ue_q     <= (upper_cnt_d == '0);
    end
    if (s1_adv) begin
      out_data_q <= {4'b0000, s1_ue_q, s1_le_q, s1_status_q, s1_top};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

// ----- rtl/core/dssm_ram.sv -----
// ----------------------------------------------------------------------------
// Dual stack word store
// Single-port-write, single-port-read synchronous memory with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dssm_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int AW    = 4
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/dssm_checker.sv -----
// ----------------------------------------------------------------------------
// Dual stack shared memory checker
// Port-level assertions on the result stream of the dual stack block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "dual_stack_shared_memory_top_defines.svh"

module dssm_checker
  import dssm_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [1:0]            res_status;
  logic [VALUE_BITS-1:0] res_top;
  logic                  out_wait;
  logic                  status_legal;
  logic                  res_ovf;
  logic                  res_unf;
  logic                  top_zero;
  logic                  top_ones;

  assign res_status   = m_axis_tdata[VALUE_BITS+1:VALUE_BITS];
  assign res_top      = m_axis_tdata[VALUE_BITS-1:0];
  assign out_wait     = m_axis_tvalid && !m_axis_tready;
  assign status_legal = (res_status == ST_OK) || (res_status == ST_OVERFLOW) ||
                        (res_status == ST_UNDERFLOW);
  assign res_ovf      = m_axis_tvalid && (res_status == ST_OVERFLOW);
  assign res_unf      = m_axis_tvalid && (res_status == ST_UNDERFLOW);
  assign top_zero     = (res_top == '0);
  assign top_ones     = (res_top == '1);

  `DSSM_ASSERT_NEXT(a_out_hold, out_wait, m_axis_tvalid && $stable(m_axis_tdata))
  `DSSM_ASSERT_IMPLY(a_status_code, m_axis_tvalid, status_legal)
  `DSSM_ASSERT_IMPLY(a_overflow_top, res_ovf, top_zero)
  `DSSM_ASSERT_IMPLY(a_underflow_top, res_unf, top_zero || top_ones)

endmodule

bind dual_stack_shared_memory_top dssm_checker u_dssm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// Dual stack shared memory testbench
// Drives push, pop and peek commands and the unused code on both stacks through the command
// stream and predicts every result from an internal copy of the two stacks
// and the capacity register. Each returned result is checked field by field
// in order. Several capacity settings run in turn, from zero up to values
// above the store depth. Sender gaps and receiver stalls change from phase
// to phase, and one phase holds the receiver off until the block stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import dssm_pkg::*;

  localparam int DEPTH           = 16;
  localparam int HOLD_CYCLES     = 120;
  localparam int WATCHDOG_CYCLES = 5000;
  localparam int PHASE_ITEMS     = 140;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic        sel;
    logic [31:0] value;
  } command_t;

  typedef struct packed {
    logic [31:0] top;
    status_e     status;
    logic        lower_empty;
    logic        upper_empty;
  } outcome_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CAP_BITS-1:0]    cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  command_t    command_q[$];
  outcome_t    outcome_q[$];
  logic [31:0] word_store [DEPTH];
  int unsigned capacity_reg = CAP_RESET;
  int unsigned lower_cnt    = 0;
  int unsigned upper_cnt    = 0;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int offered_cnt   = 0;
  int taken_cnt     = 0;
  int err_cnt       = 0;
  int quiet_cycles  = 0;
  int hold_trig     = 0;
  int hold_seen     = 0;
  int hold_left     = 0;

  dual_stack_shared_memory_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic outcome_t stack_outcome(command_t c);
    outcome_t    r;
    int unsigned cap;
    int unsigned depth_n;
    cap = (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
    r.top = '0;
    r.status = ST_OK;
    case (c.op)
      OP_PUSH: begin
        if (lower_cnt + upper_cnt < cap) begin
          if (c.sel) begin
            word_store[cap - 1 - upper_cnt] = c.value;
            upper_cnt++;
          end else begin
            word_store[lower_cnt] = c.value;
            lower_cnt++;
          end
        end else begin
          r.status = ST_OVERFLOW;
        end
      end
      OP_POP: begin
        if (c.sel) begin
          if (upper_cnt > 0) upper_cnt--;
          else r.status = ST_UNDERFLOW;
        end else begin
          if (lower_cnt > 0) lower_cnt--;
          else r.status = ST_UNDERFLOW;
        end
      end
      OP_PEEK: begin
        depth_n = c.sel ? upper_cnt : lower_cnt;
        if (depth_n == 0) begin
          r.status = ST_UNDERFLOW;
          r.top = '1;
        end else begin
          r.top = c.sel ? word_store[cap - upper_cnt] : word_store[lower_cnt - 1];
        end
      end
      default: ;
    endcase
    r.lower_empty = (lower_cnt == 0);
    r.upper_empty = (upper_cnt == 0);
    return r;
  endfunction

  function automatic void add_cmd(logic [1:0] op, logic sel, logic [31:0] value);
    command_t c;
    c.op = op;
    c.sel = sel;
    c.value = value;
    command_q.push_back(c);
  endfunction

  function automatic logic [31:0] random_word();
    logic [31:0] w;
    case ($urandom_range(11))
      0: w = 32'h8000_0000;
      1: w = 32'h7fff_ffff;
      2: w = 32'hffff_ffff;
      3: w = 32'h0000_0000;
      default: w = $urandom();
    endcase
    return w;
  endfunction

  // Stretches alternate between filling and draining so that both the
  // overflow and the underflow boundaries are reached often.
  function automatic void add_random(int n);
    int          r;
    int          push_pct;
    int          pop_pct;
    logic [1:0]  op;
    for (int k = 0; k < n; k++) begin
      push_pct = ((k / 24) % 2 == 0) ? 70 : 10;
      pop_pct  = ((k / 24) % 2 == 0) ? 15 : 55;
      r = $urandom_range(99);
      if (r >= 98) op = OP_UNUSED;
      else if (r < push_pct) op = OP_PUSH;
      else if (r < push_pct + pop_pct) op = OP_POP;
      else op = OP_PEEK;
      add_cmd(op, 1'($urandom_range(1)), random_word());
    end
  endfunction

  task automatic wait_idle();
    while (command_q.size() != 0 || s_axis_tvalid || outcome_q.size() != 0)
      @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [CAP_BITS-1:0] value);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    capacity_reg = value;
    lower_cnt = 0;
    upper_cnt = 0;
  endtask

  always @(negedge clk_i) begin : driver
    command_t nxt;
    if (!s_axis_tvalid || taken_cnt == offered_cnt) begin
      if (command_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = command_q.pop_front();
        s_axis_tdata  <= {{(IN_TDATA_W - 34){1'b0}}, nxt.value, nxt.op};
        s_axis_tuser  <= nxt.sel;
        s_axis_tvalid <= 1'b1;
        offered_cnt++;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : receiver
    if (hold_trig != hold_seen) begin
      hold_seen = hold_trig;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin : monitor
    command_t    c;
    outcome_t    want;
    logic [39:0] got;
    logic        moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        c.op    = s_axis_tdata[1:0];
        c.value = s_axis_tdata[33:2];
        c.sel   = s_axis_tuser;
        outcome_q.push_back(stack_outcome(c));
        taken_cnt++;
        moved = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        got = m_axis_tdata;
        if (outcome_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("unexpected result transfer: %h", got);
        end else begin
          want = outcome_q.pop_front();
          if (got[31:0] !== want.top || got[33:32] !== want.status ||
              got[34] !== want.lower_empty || got[35] !== want.upper_empty) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("mismatch: top %h/%h status %0d/%0d lower_empty %b/%b upper_empty %b/%b",
                       want.top, got[31:0], want.status, got[33:32],
                       want.lower_empty, got[34], want.upper_empty, got[35]);
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [CAP_BITS-1:0] caps [8];
    caps = '{5'd16, 5'd3, 5'd31, 5'd1, 5'd8, 5'd2, 5'd16, 5'd5};
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset capacity: empty stacks, word extremes, the unused code.
    add_cmd(OP_PEEK, 1'b0, 32'h0000_0000);
    add_cmd(OP_POP, 1'b1, 32'hffff_ffff);
    add_cmd(OP_PUSH, 1'b0, 32'h7fff_ffff);
    add_cmd(OP_PUSH, 1'b1, 32'h8000_0000);
    add_cmd(OP_PEEK, 1'b0, 32'h0000_0000);
    add_cmd(OP_PEEK, 1'b1, 32'h0000_0000);
    add_cmd(OP_PUSH, 1'b1, 32'hffff_ffff);
    add_cmd(OP_PEEK, 1'b1, 32'h0000_0000);
    add_cmd(OP_UNUSED, 1'b1, 32'hffff_ffff);
    add_cmd(OP_POP, 1'b1, 32'h0000_0000);
    add_cmd(OP_PEEK, 1'b1, 32'h0000_0000);
    add_cmd(OP_POP, 1'b0, 32'h0000_0000);
    add_cmd(OP_POP, 1'b0, 32'h0000_0000);
    add_cmd(OP_PUSH, 1'b0, 32'h5555_aaaa);

    // A single word shared by both stacks.
    write_capacity(5'd1);
    add_cmd(OP_PUSH, 1'b1, 32'h1234_5678);
    add_cmd(OP_PUSH, 1'b0, 32'h0000_0001);
    add_cmd(OP_PEEK, 1'b1, 32'h0000_0000);
    add_cmd(OP_POP, 1'b1, 32'h0000_0000);
    add_cmd(OP_PUSH, 1'b0, 32'h0000_0000);
    add_cmd(OP_PEEK, 1'b0, 32'h0000_0000);

    // No room at all, and the write must have emptied the lower stack.
    write_capacity(5'd0);
    add_cmd(OP_PEEK, 1'b0, 32'h0000_0000);
    add_cmd(OP_PUSH, 1'b0, 32'h0000_0000);
    add_cmd(OP_PUSH, 1'b1, 32'hffff_ffff);
    add_cmd(OP_PEEK, 1'b1, 32'h0000_0000);

    for (int p = 0; p < 8; p++) begin
      write_capacity(caps[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 72; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 72; end
        default: begin send_idle_pct = 24; stall_pct = 24; end
      endcase
      add_random(PHASE_ITEMS);
      if (p == 4) hold_trig++;
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0 && outcome_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- dual_stack_shared_memory_top.f -----
+incdir+rtl/core
rtl/core/dssm_pkg.sv
rtl/core/dssm_ram.sv
rtl/core/dual_stack_shared_memory_top.sv
rtl/core/dssm_checker.sv
test/tb.sv
